// ===== rtl/core/kfc_pkg.sv =====
// Shared types and constants for the kicker fire controller core.
// Depends on nothing; the core top level, config registers, input stage and channel refer to it by scoped names.
package kfc_pkg;

    // Command codes carried by an input transaction
    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_KICK  = 3'd1;
    localparam logic [2:0] CMD_SENSE = 3'd2;
    localparam logic [2:0] CMD_OFF   = 3'd3;
    localparam logic [2:0] CMD_CLEAR = 3'd4;

    // Codes reported in last_kind
    localparam logic [1:0] KIND_NONE = 2'h0;
    localparam logic [1:0] KIND_CHIP = 2'h1;
    localparam logic [1:0] KIND_FLAT = 2'h2;

    // Configuration register map (register index = paddr[2])
    localparam int          PADDR_W              = 3;
    localparam int          PDATA_W              = 32;
    localparam logic        REG_COOLDOWN_TICKS   = 1'b0;
    localparam logic        REG_COMMANDS_ENABLED = 1'b1;
    localparam logic [15:0] COOLDOWN_TICKS_RESET = 16'd500;

    // Default cooldown counter width
    localparam int COUNT_WIDTH_DEFAULT = 16;

    // Configuration register contents
    typedef struct packed {
        logic [15:0] cooldown_ticks;
        logic        commands_enabled;
    } cfg_t;

    // One registered input transaction
    typedef struct packed {
        logic [2:0] command;
        logic [7:0] flat_request;
        logic [7:0] chip_request;
        logic       ball_present;
        logic       cap_ok;
    } in_item_t;

    // One result transaction
    typedef struct packed {
        logic [7:0] flat_fire;
        logic [7:0] chip_fire;
        logic       drivers_off;
        logic       cap_low_flag;
        logic       busy_refused;
        logic       sensor_armed;
        logic [1:0] last_kind;
    } out_item_t;

    // Controls from the sequencing logic into one kicker channel
    typedef struct packed {
        logic step;     // item consumed this cycle
        logic tick;     // decrement nonzero cooldown
        logic clear;    // zero the cooldown
        logic attempt;  // fire attempt with a nonzero strength
        logic cap_ok;   // capacitor high enough
    } ch_ctrl_t;

    // Status of one kicker channel for the current item
    typedef struct packed {
        logic busy;      // attempt refused by cooldown
        logic accepted;  // attempt reached the capacitor check
        logic fire;      // channel fires now
    } ch_stat_t;

endpackage

// ===== rtl/core/kfc_in_if.sv =====
// Input channel interface: valid/ready handshake carrying one command transaction.
// Depends on nothing.
interface kfc_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [7:0] flat_request;
    logic [7:0] chip_request;
    logic       ball_present;
    logic       cap_ok;

    modport source (output valid, output command, output flat_request,
                    output chip_request, output ball_present, output cap_ok,
                    input ready);
    modport sink   (input valid, input command, input flat_request,
                    input chip_request, input ball_present, input cap_ok,
                    output ready);
endinterface

// ===== rtl/core/kfc_out_if.sv =====
// Result channel interface: valid/ready handshake carrying one result transaction.
// Depends on nothing.
interface kfc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] flat_fire;
    logic [7:0] chip_fire;
    logic       drivers_off;
    logic       cap_low_flag;
    logic       busy_refused;
    logic       sensor_armed;
    logic [1:0] last_kind;

    modport source (output valid, output flat_fire, output chip_fire,
                    output drivers_off, output cap_low_flag, output busy_refused,
                    output sensor_armed, output last_kind, input ready);
    modport sink   (input valid, input flat_fire, input chip_fire,
                    input drivers_off, input cap_low_flag, input busy_refused,
                    input sensor_armed, input last_kind, output ready);
endinterface

// ===== rtl/core/kicker_fire_controller_core.sv =====
// Kicker fire controller top level: input stage, config registers, two channels,
// pending/arm sequencing and result register.
// Depends on kfc_pkg, kfc_in_if, kfc_out_if, kfc_cfg_regs, kfc_in_stage, kfc_channel.
//
// Usage:
//   cmd_ch carries command transactions (tick, kick command, ball sensor event,
//   all off, clear cooldowns); res_ch returns exactly one result per command.
//   Both use valid/ready; a transaction moves when valid and ready are high.
//   The APB-style port holds cooldown_ticks (0x0) and commands_enabled (0x4);
//   write it only while no command is in flight.
// Flow: an accepted command waits in the input register; its result is registered
//   in the result register. Throughput: one command per clock while res_ch.ready
//   stays high, set by the single decision pass between the two registers.
// Reset (rst_n low, asynchronous): cooldowns, pending strengths, arm flag,
//   capacitor-low flag and last kind clear; cooldown_ticks returns to 500 and
//   commands are disabled.
// Stall: while res_ch.ready is low the result is held; one more command may
//   wait in the input register, then cmd_ch.ready drops until the result moves.
module kicker_fire_controller_core #(
    parameter int COUNT_WIDTH = kfc_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [kfc_pkg::PADDR_W-1:0]  paddr,
    input  logic [kfc_pkg::PDATA_W-1:0]  pwdata,
    output logic [kfc_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    kfc_in_if.sink                       cmd_ch,
    kfc_out_if.source                    res_ch
);

    kfc_pkg::cfg_t      cfg;
    kfc_pkg::in_item_t  item;
    logic               item_valid;
    logic               advance;
    logic               out_free;

    kfc_pkg::ch_ctrl_t  flat_ctrl;
    kfc_pkg::ch_ctrl_t  chip_ctrl;
    kfc_pkg::ch_stat_t  flat_stat;
    kfc_pkg::ch_stat_t  chip_stat;

    logic [7:0]         pending_flat_reg, pending_flat_next;
    logic [7:0]         pending_chip_reg, pending_chip_next;
    logic               armed_reg, armed_next;
    logic               cap_low_reg, cap_low_next;
    logic [1:0]         last_kind_reg, last_kind_next;

    logic               out_valid_reg;
    kfc_pkg::out_item_t out_item_reg;
    kfc_pkg::out_item_t out_item_next;

    logic               is_tick, is_kick, is_sense, is_off, is_clear;
    logic [7:0]         flat_strength, chip_strength;

    kfc_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    kfc_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_ch     (cmd_ch),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // Pipeline flow: consume the input register when the result register is free
    assign out_free = !out_valid_reg || res_ch.ready;
    assign advance  = item_valid && out_free;

    // Command decode
    always_comb
    begin
        is_tick  = 1'b0;
        is_kick  = 1'b0;
        is_sense = 1'b0;
        is_off   = 1'b0;
        is_clear = 1'b0;
        case (item.command)
            kfc_pkg::CMD_TICK:  is_tick  = 1'b1;
            kfc_pkg::CMD_KICK:  is_kick  = cfg.commands_enabled;
            kfc_pkg::CMD_SENSE: is_sense = 1'b1;
            kfc_pkg::CMD_OFF:   is_off   = 1'b1;
            kfc_pkg::CMD_CLEAR: is_clear = 1'b1;
            default: ;
        endcase
    end

    // Strength offered to each channel: direct request or pending value
    assign flat_strength = is_kick ? item.flat_request : pending_flat_reg;
    assign chip_strength = is_kick ? item.chip_request : pending_chip_reg;

    // Channel controls; a sensor event tries chip only when no flat is pending
    always_comb
    begin
        flat_ctrl.step    = advance;
        flat_ctrl.tick    = is_tick;
        flat_ctrl.clear   = is_off || is_clear;
        flat_ctrl.cap_ok  = item.cap_ok;
        flat_ctrl.attempt = (flat_strength != 8'd0) &&
                            ((is_kick && item.ball_present) || (is_sense && armed_reg));
        chip_ctrl.step    = advance;
        chip_ctrl.tick    = is_tick;
        chip_ctrl.clear   = is_off || is_clear;
        chip_ctrl.cap_ok  = item.cap_ok;
        chip_ctrl.attempt = (chip_strength != 8'd0) &&
                            ((is_kick && item.ball_present) ||
                             (is_sense && armed_reg && pending_flat_reg == 8'd0));
    end

    kfc_channel #(.COUNT_WIDTH(COUNT_WIDTH)) u_flat (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (flat_ctrl),
        .cooldown_ticks (cfg.cooldown_ticks),
        .stat           (flat_stat)
    );

    kfc_channel #(.COUNT_WIDTH(COUNT_WIDTH)) u_chip (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (chip_ctrl),
        .cooldown_ticks (cfg.cooldown_ticks),
        .stat           (chip_stat)
    );

    // Pending strengths, arm flag and sticky status
    always_comb
    begin
        pending_flat_next = pending_flat_reg;
        pending_chip_next = pending_chip_reg;
        armed_next        = armed_reg;
        if (is_kick)
        begin
            pending_flat_next = item.flat_request;
            pending_chip_next = item.chip_request;
            if (item.flat_request == 8'd0 && item.chip_request == 8'd0)
                armed_next = 1'b0;
            else if (!item.ball_present)
                armed_next = 1'b1;
        end
        else if (is_sense)
        begin
            if (armed_reg)
            begin
                pending_flat_next = 8'd0;
                pending_chip_next = 8'd0;
            end
            armed_next = 1'b0;
        end

        // Any attempt past the cooldown check samples the capacitor
        cap_low_next = (flat_stat.accepted || chip_stat.accepted) ? !item.cap_ok
                                                                   : cap_low_reg;

        // A chip fire wins when both channels fire on the same item
        if (chip_stat.fire)
            last_kind_next = kfc_pkg::KIND_CHIP;
        else if (flat_stat.fire)
            last_kind_next = kfc_pkg::KIND_FLAT;
        else
            last_kind_next = last_kind_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_flat_reg <= 8'd0;
            pending_chip_reg <= 8'd0;
            armed_reg        <= 1'b0;
            cap_low_reg      <= 1'b0;
            last_kind_reg    <= kfc_pkg::KIND_NONE;
        end
        else if (advance)
        begin
            pending_flat_reg <= pending_flat_next;
            pending_chip_reg <= pending_chip_next;
            armed_reg        <= armed_next;
            cap_low_reg      <= cap_low_next;
            last_kind_reg    <= last_kind_next;
        end
    end

    // Result assembly
    always_comb
    begin
        out_item_next.flat_fire    = flat_stat.fire ? flat_strength : 8'd0;
        out_item_next.chip_fire    = chip_stat.fire ? chip_strength : 8'd0;
        out_item_next.drivers_off  = is_off;
        out_item_next.cap_low_flag = cap_low_next;
        out_item_next.busy_refused = flat_stat.busy || chip_stat.busy;
        out_item_next.sensor_armed = armed_next;
        out_item_next.last_kind    = last_kind_next;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (res_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_item_reg <= out_item_next;
    end

    assign res_ch.valid        = out_valid_reg;
    assign res_ch.flat_fire    = out_item_reg.flat_fire;
    assign res_ch.chip_fire    = out_item_reg.chip_fire;
    assign res_ch.drivers_off  = out_item_reg.drivers_off;
    assign res_ch.cap_low_flag = out_item_reg.cap_low_flag;
    assign res_ch.busy_refused = out_item_reg.busy_refused;
    assign res_ch.sensor_armed = out_item_reg.sensor_armed;
    assign res_ch.last_kind    = out_item_reg.last_kind;

    // A held input transaction is not lost while the result side stalls
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !advance) |=> item_valid)
        else $error("input register dropped a transaction while stalled");

    // A fire always comes with a good capacitor observation
    a_fire_cap_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_item_reg.flat_fire != 8'd0 || out_item_reg.chip_fire != 8'd0))
        |-> !out_item_reg.cap_low_flag)
        else $error("fire reported with capacitor low");

    // An all-off result never carries a fire
    a_off_no_fire: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.drivers_off)
        |-> (out_item_reg.flat_fire == 8'd0 && out_item_reg.chip_fire == 8'd0))
        else $error("fire reported together with drivers off");

    // A sensor event always leaves the sensor disarmed
    a_sense_disarms: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && is_sense) |=> !armed_reg)
        else $error("sensor still armed after a sensor event");

    // A chip fire is reported as the last kind
    a_chip_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && chip_stat.fire) |=> (last_kind_reg == kfc_pkg::KIND_CHIP))
        else $error("chip fire not recorded as last kind");

endmodule

// ===== rtl/core/kfc_cfg_regs.sv =====
// APB-style configuration registers: cooldown reload value and command enable.
// Depends on kfc_pkg.
module kfc_cfg_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [kfc_pkg::PADDR_W-1:0]  paddr,
    input  logic [kfc_pkg::PDATA_W-1:0]  pwdata,
    output logic [kfc_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output kfc_pkg::cfg_t                cfg
);

    kfc_pkg::cfg_t cfg_reg;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // Register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cooldown_ticks   <= kfc_pkg::COOLDOWN_TICKS_RESET;
            cfg_reg.commands_enabled <= 1'b0;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                kfc_pkg::REG_COOLDOWN_TICKS:   cfg_reg.cooldown_ticks   <= pwdata[15:0];
                kfc_pkg::REG_COMMANDS_ENABLED: cfg_reg.commands_enabled <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (paddr[2])
            kfc_pkg::REG_COOLDOWN_TICKS:
                prdata = {{(kfc_pkg::PDATA_W-16){1'b0}}, cfg_reg.cooldown_ticks};
            kfc_pkg::REG_COMMANDS_ENABLED:
                prdata = {{(kfc_pkg::PDATA_W-1){1'b0}}, cfg_reg.commands_enabled};
            default:
                prdata = '0;
        endcase
    end

endmodule

// ===== rtl/core/kfc_in_stage.sv =====
// Input register stage: captures one command transaction and holds it until consumed.
// Depends on kfc_pkg and kfc_in_if.
module kfc_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    kfc_in_if.sink            cmd_ch,
    input  logic              advance,
    output logic              item_valid,
    output kfc_pkg::in_item_t item
);

    logic              valid_reg;
    kfc_pkg::in_item_t item_reg;
    logic              take;

    // Ready whenever the stage is empty or drains this cycle
    assign cmd_ch.ready = !valid_reg || advance;
    assign take         = cmd_ch.valid && cmd_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (take)
            valid_reg <= 1'b1;
        else if (advance)
            valid_reg <= 1'b0;
    end

    // Payload capture, no reset needed
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.command      <= cmd_ch.command;
            item_reg.flat_request <= cmd_ch.flat_request;
            item_reg.chip_request <= cmd_ch.chip_request;
            item_reg.ball_present <= cmd_ch.ball_present;
            item_reg.cap_ok       <= cmd_ch.cap_ok;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/core/kfc_channel.sv =====
// One kicker channel: cooldown counter plus the refuse / capacitor / fire decision.
// Depends on kfc_pkg.
module kfc_channel #(
    parameter int COUNT_WIDTH = kfc_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  kfc_pkg::ch_ctrl_t  ctrl,
    input  logic [15:0]        cooldown_ticks,
    output kfc_pkg::ch_stat_t  stat
);

    logic [COUNT_WIDTH-1:0]    cooldown_reg;
    logic [COUNT_WIDTH-1:0]    cooldown_next;
    logic [COUNT_WIDTH+15:0]   reload_wide;
    logic [COUNT_WIDTH-1:0]    reload;
    logic                      idle;

    // Reload value cut or zero-extended to the counter width
    assign reload_wide = {{COUNT_WIDTH{1'b0}}, cooldown_ticks};
    assign reload      = reload_wide[COUNT_WIDTH-1:0];

    // Fire decision
    assign idle          = (cooldown_reg == '0);
    assign stat.busy     = ctrl.attempt && !idle;
    assign stat.accepted = ctrl.attempt && idle;
    assign stat.fire     = ctrl.attempt && idle && ctrl.cap_ok;

    // Counter update
    always_comb
    begin
        cooldown_next = cooldown_reg;
        if (ctrl.clear)
            cooldown_next = '0;
        else if (ctrl.tick && !idle)
            cooldown_next = cooldown_reg - COUNT_WIDTH'(1);
        else if (stat.fire)
            cooldown_next = reload;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cooldown_reg <= '0;
        else if (ctrl.step)
            cooldown_reg <= cooldown_next;
    end

endmodule
